/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the word acceptor.
// No dependencies; included by bare file name; expects clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, suppressed while reset is high.
`define ASSERT_IMPL(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m failed");

// Implication checked every clock, reset included.
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("%m failed");

`endif

/* rtl/enwa_pkg.sv */
// Shared types and constants of the epsilon-NFA word acceptor.
// No dependencies; used by the top level and its checker.
`default_nettype none

package enwa_pkg;

   localparam int NUM_STATES  = 16;
   localparam int STATE_BITS  = $clog2(NUM_STATES);
   localparam int SYMBOL_BITS = 8;
   localparam int MOVE_ABITS  = STATE_BITS + SYMBOL_BITS;
   localparam int CNT_BITS    = STATE_BITS + 1;

   localparam int FIELD_STATE_BITS  = 4;
   localparam int FIELD_SYMBOL_BITS = 8;
   localparam int REQ_DATA_BITS     = 24;
   localparam int RSP_DATA_BITS     = 8;
   localparam int CSR_DATA_BITS     = 16;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SYM = 2'd1,
      FUNC_QRY = 2'd2
   } func_type;

   typedef enum logic {
      CSR_INITIAL_STATE = 1'b0,
      CSR_FINAL_MASK    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR,
      ST_START,
      ST_MOVE,
      ST_CLOSE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

/* rtl/epsilon_nfa_word_acceptor_top.sv */
// Epsilon-NFA word acceptor: move table in a synchronous RAM, epsilon table in flops.
// Depends on enwa_pkg.
//
//  channel  dir  fields (low bit up)
//  req_*    in   tdata: from_state[3:0] to_state[7:4] is_epsilon[8] symbol[16:9];
//                tuser: func[1:0]; tlast: last
//  rsp_*    out  tdata: accepted[0]
//  csr_*    in   addr 0 initial_state, addr 1 final_mask
//
// One word at a time. Epsilon add: a flop table write; labeled add: a RAM read-modify-write.
// Symbol: a walk over the move RAM, one state per cycle, then closure passes until
// the set is stable; the first symbol of a word adds start passes before the walk.
// Empty word query: start passes, then the emit state. Every result goes through ST_EMIT.
// After reset a clearing pass over all 4096 move RAM entries runs with req_tready low.
// One result register; an item waits to emit while the previous result stalls.
`default_nettype none

module epsilon_nfa_word_acceptor_top import enwa_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   // from_state, to_state, is_epsilon, symbol, zero fill
   input  wire  [REQ_DATA_BITS-1:0] req_tdata,
   // func
   input  wire  [1:0]               req_tuser,
   input  wire                      req_tlast,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   // accepted, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire                      csr_we,
   input  wire                      csr_addr,
   input  wire  [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef logic [NUM_STATES-1:0] set_type;

   state_type                    state_ff, state_in;
   logic [MOVE_ABITS-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   set_type                      set_ff, set_in;
   set_type                      nxt_ff, nxt_in;
   logic                         any_ff, any_in;
   logic                         in_word_ff, in_word_in;
   logic                         rej_ff, rej_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_acc_ff, rsp_acc_in;
   logic [FIELD_STATE_BITS-1:0]  init_ff;
   set_type                      final_ff;
   set_type                      eps_ff [NUM_STATES];

   func_type                     func_ff;
   logic [FIELD_STATE_BITS-1:0]  from_ff, to_ff;
   logic [SYMBOL_BITS-1:0]       sym_ff;
   logic                         last_ff;

   logic [NUM_STATES-1:0]        move_mem [2**MOVE_ABITS];
   logic [NUM_STATES-1:0]        rd_data_ff;
   logic [MOVE_ABITS-1:0]        rd_addr, wr_addr;
   logic [NUM_STATES-1:0]        wr_data;
   logic                         mem_we;

   logic [FIELD_STATE_BITS-1:0]  req_from, req_to;
   logic                         req_eps;
   logic [FIELD_SYMBOL_BITS-1:0] req_symbol;
   logic                         req_take;
   logic                         eps_we;

   set_type                      start_set, closed, mv_data, nxt_fin;
   logic                         any_fin;
   logic [STATE_BITS-1:0]        prev_idx;

   assign req_from   = req_tdata[3:0];
   assign req_to     = req_tdata[7:4];
   assign req_eps    = req_tdata[8];
   assign req_symbol = req_tdata[16:9];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-1){1'b0}}, rsp_acc_ff};

   assign start_set = (32'(init_ff) < NUM_STATES) ?
                      (set_type'(1) << init_ff) : '0;

   always_comb begin
      closed = set_ff;
      for (int s = 0; s < NUM_STATES; s++) begin
         if (set_ff[s]) begin
            closed = closed | eps_ff[s];
         end
      end
   end

   assign prev_idx = cnt_ff[STATE_BITS-1:0] - STATE_BITS'(1);
   assign mv_data  = set_ff[prev_idx] ? rd_data_ff : '0;
   assign nxt_fin  = nxt_ff | mv_data;
   assign any_fin  = any_ff | (|rd_data_ff);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         final_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_INITIAL_STATE: init_ff  <= csr_wdata[FIELD_STATE_BITS-1:0];
            CSR_FINAL_MASK:    final_ff <= csr_wdata[NUM_STATES-1:0];
            default: ;
         endcase
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= func_type'(req_tuser);
         from_ff <= req_from;
         to_ff   <= req_to;
         sym_ff  <= req_symbol[SYMBOL_BITS-1:0];
         last_ff <= req_tlast;
      end
   end

   // epsilon table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STATES; s++) begin
            eps_ff[s] <= '0;
         end
      end else if (eps_we) begin
         eps_ff[req_from[STATE_BITS-1:0]][req_to[STATE_BITS-1:0]] <= 1'b1;
      end
   end

   // move table RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         move_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= move_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cnt_ff       <= '0;
         set_ff       <= '0;
         nxt_ff       <= '0;
         any_ff       <= 1'b0;
         in_word_ff   <= 1'b0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_acc_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cnt_ff       <= cnt_in;
         set_ff       <= set_in;
         nxt_ff       <= nxt_in;
         any_ff       <= any_in;
         in_word_ff   <= in_word_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_acc_ff   <= rsp_acc_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cnt_in       = cnt_ff;
      set_in       = set_ff;
      nxt_in       = nxt_ff;
      any_in       = any_ff;
      in_word_in   = in_word_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_acc_in   = rsp_acc_ff;
      rd_addr      = {cnt_ff[STATE_BITS-1:0], sym_ff};
      wr_addr      = {from_ff[STATE_BITS-1:0], sym_ff};
      wr_data      = rd_data_ff | (set_type'(1) << to_ff[STATE_BITS-1:0]);
      mem_we       = 1'b0;
      eps_we       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + MOVE_ABITS'(1);
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = {req_from[STATE_BITS-1:0], req_symbol[SYMBOL_BITS-1:0]};
            if (req_take) begin
               case (func_type'(req_tuser))
                  FUNC_ADD: begin
                     if (req_eps) begin
                        eps_we = 1'b1;
                     end else begin
                        state_in = ST_ADD_WR;
                     end
                  end
                  FUNC_SYM: begin
                     cnt_in = '0;
                     nxt_in = '0;
                     any_in = 1'b0;
                     if (!in_word_ff) begin
                        set_in     = start_set;
                        rej_in     = 1'b0;
                        in_word_in = 1'b1;
                        state_in   = ST_START;
                     end else if (rej_ff) begin
                        state_in = req_tlast ? ST_EMIT : ST_IDLE;
                     end else begin
                        state_in = ST_MOVE;
                     end
                  end
                  FUNC_QRY: begin
                     in_word_in = 1'b0;
                     rej_in     = 1'b0;
                     set_in     = start_set;
                     state_in   = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_WR: begin
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_START: begin
            set_in = closed;
            if (closed == set_ff) begin
               state_in = (func_ff == FUNC_QRY) ? ST_EMIT : ST_MOVE;
            end
         end
         ST_MOVE: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff != '0) begin
               nxt_in = nxt_fin;
               any_in = any_fin;
            end
            if (32'(cnt_ff) == NUM_STATES) begin
               if (!any_fin || set_ff == '0) begin
                  rej_in   = 1'b1;
                  state_in = last_ff ? ST_EMIT : ST_IDLE;
               end else begin
                  set_in   = nxt_fin;
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            set_in = closed;
            if (closed == set_ff) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = !rej_ff && (|(set_ff & final_ff));
               in_word_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/enwa_checker.sv */
// Port-level checker for the word acceptor, bound to the top level.
// Depends on enwa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module enwa_checker import enwa_pkg::*; (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_tvalid,
   input wire                     req_tready,
   input wire [1:0]               req_tuser,
   input wire                     rsp_tvalid,
   input wire                     rsp_tready,
   input wire [RSP_DATA_BITS-1:0] rsp_tdata
);

   `ASSERT_IMPL(rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_ALWAYS(rsp_idle_after_reset, reset |=> !rsp_tvalid)
   `ASSERT_ALWAYS(clear_blocks_req, reset |=> !req_tready)
   `ASSERT_IMPL(query_busy, req_tvalid && req_tready && req_tuser == FUNC_QRY |=> !req_tready)
   `ASSERT_IMPL(emit_from_busy, $rose(rsp_tvalid) |-> !$past(req_tready))

endmodule

bind epsilon_nfa_word_acceptor_top enwa_checker u_enwa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* test/epsilon_nfa_word_acceptor_top_test.sv */
// Self-checking test for epsilon_nfa_word_acceptor_top.
// Loads transitions, streams words and checks each verdict against an NFA predictor.
// Depends on enwa_pkg and the top level only.
`timescale 1ns / 1ps

module epsilon_nfa_word_acceptor_top_test;
   import enwa_pkg::*;

   localparam logic [1:0] FUNC_NOP = 2'd3;
   localparam int SETTLE_CYCLES   = 64;
   localparam int RX_HOLD_CYCLES  = 300;
   localparam int NUM_PHASES      = 16;
   localparam int PHASE_WORDS     = 78;
   localparam int PRINT_CAP       = 20;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_INIT,
      ROW_MASK
   } probe_kind_type;

   typedef struct packed {
      probe_kind_type kind;
      logic [1:0]  fn;
      logic [3:0]  src;
      logic [3:0]  dst;
      logic        eps;
      logic [7:0]  sym;
      logic        tl;
      logic [15:0] value;
      logic        known;
      logic        verdict;
   } probe_row_type;

   localparam int NUM_PROBES = 25;
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      // zero final mask after reset
      '{ROW_ITEM, FUNC_QRY, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 16'h0000, 1'b1, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 16'h0000, 1'b1, 1'b0},
      '{ROW_MASK, FUNC_ADD, 4'd0,  4'd0,  1'b0, 8'h00, 1'b0, 16'h8000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_ADD, 4'd0,  4'd15, 1'b0, 8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_ADD, 4'd15, 4'd0,  1'b1, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b0},
      // epsilon add leaves 0x00 out of the alphabet
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_QRY, 4'd15, 4'd15, 1'b1, 8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_NOP, 4'd15, 4'd15, 1'b1, 8'hFF, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b1, 16'h0000, 1'b0, 1'b0},
      // query abandons a word in progress
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_QRY, 4'd0,  4'd0,  1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0},
      // transition added mid-word
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_ADD, 4'd15, 4'd7,  1'b0, 8'h80, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'h80, 1'b1, 16'h0000, 1'b0, 1'b0},
      // active set runs empty, stays rejected
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'h80, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'hFF, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_ADD, 4'd15, 4'd0,  1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ROW_INIT, FUNC_ADD, 4'd0,  4'd0,  1'b0, 8'h00, 1'b0, 16'h000F, 1'b0, 1'b0},
      '{ROW_MASK, FUNC_ADD, 4'd0,  4'd0,  1'b0, 8'h00, 1'b0, 16'hFFFF, 1'b0, 1'b0},
      // full mask, non-empty start set
      '{ROW_ITEM, FUNC_QRY, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 16'h0000, 1'b1, 1'b1},
      '{ROW_ITEM, FUNC_SYM, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ROW_ITEM, FUNC_ADD, 4'd0,  4'd0,  1'b1, 8'h55, 1'b0, 16'h0000, 1'b0, 1'b0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0]               req_tuser = FUNC_ADD;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_addr = CSR_INITIAL_STATE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // typed verdict of a table row, travels with the word
   logic row_known = 1'b0;
   logic row_verdict = 1'b0;

   int   tx_idle_pct = 34;
   int   rx_idle_pct = 34;
   logic rx_hold_req = 1'b0;
   int   words_sent = 0;
   int   mismatch_count = 0;

   // NFA image
   logic [NUM_STATES-1:0] move_bits [0:(1<<MOVE_ABITS)-1];
   logic [NUM_STATES-1:0] eps_bits [0:NUM_STATES-1];
   logic [(1<<SYMBOL_BITS)-1:0] alphabet;
   logic [NUM_STATES-1:0] active_states;
   logic                  in_word;
   logic                  word_dead;
   logic [STATE_BITS-1:0] start_state;
   logic [NUM_STATES-1:0] final_states;

   bit verdicts_due [$];

   epsilon_nfa_word_acceptor_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [NUM_STATES-1:0] eps_close(input logic [NUM_STATES-1:0] set);
      logic [NUM_STATES-1:0] prev;
      int s;
      do begin
         prev = set;
         for (s = 0; s < NUM_STATES; s++)
            if (set[s])
               set |= eps_bits[s];
      end while (set != prev);
      return set;
   endfunction

   function automatic logic [NUM_STATES-1:0] start_closure();
      logic [NUM_STATES-1:0] seed;
      seed = '0;
      seed[start_state] = 1'b1;
      return eps_close(seed);
   endfunction

   function automatic logic [NUM_STATES-1:0] move_on(input logic [NUM_STATES-1:0] set,
                                                     input logic [7:0] sym);
      logic [NUM_STATES-1:0] next;
      int s;
      next = '0;
      for (s = 0; s < NUM_STATES; s++)
         if (set[s])
            next |= move_bits[(s << SYMBOL_BITS) | sym];
      return next;
   endfunction

   task automatic advance_nfa(input logic [1:0] fn, input logic [3:0] src, dst,
                              input logic eps, input logic [7:0] sym, input logic tl,
                              output bit produces, output bit accepted);
      produces = 1'b0;
      accepted = 1'b0;
      case (fn)
         FUNC_ADD: begin
            if (eps) begin
               eps_bits[src][dst] = 1'b1;
            end else begin
               move_bits[{src, sym}][dst] = 1'b1;
               alphabet[sym] = 1'b1;
            end
         end
         FUNC_SYM: begin
            if (!in_word) begin
               active_states = start_closure();
               word_dead = 1'b0;
               in_word = 1'b1;
            end
            if (!word_dead) begin
               if (!alphabet[sym] || active_states == '0)
                  word_dead = 1'b1;
               else
                  active_states = eps_close(move_on(active_states, sym));
            end
            if (tl) begin
               in_word = 1'b0;
               produces = 1'b1;
               accepted = !word_dead && (active_states & final_states) != '0;
            end
         end
         FUNC_QRY: begin
            in_word = 1'b0;
            word_dead = 1'b0;
            active_states = start_closure();
            produces = 1'b1;
            accepted = (active_states & final_states) != '0;
         end
         default: ;
      endcase
   endtask

   // results are retired before new words are predicted
   always @(posedge clock) begin : scoreboard
      bit produces;
      bit accepted;
      bit due;
      int k;
      if (reset) begin
         for (k = 0; k < (1 << MOVE_ABITS); k++)
            move_bits[k] = '0;
         for (k = 0; k < NUM_STATES; k++)
            eps_bits[k] = '0;
         alphabet = '0;
         active_states = '0;
         in_word = 1'b0;
         word_dead = 1'b0;
         start_state = '0;
         final_states = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch("result with no word pending");
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_tdata[0] !== due)
                  report_mismatch($sformatf("accepted %b, expected %b", rsp_tdata[0], due));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_INITIAL_STATE: start_state = csr_wdata[STATE_BITS-1:0];
               CSR_FINAL_MASK:    final_states = csr_wdata[NUM_STATES-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_nfa(req_tuser, req_tdata[3:0], req_tdata[7:4], req_tdata[8],
                        req_tdata[16:9], req_tlast, produces, accepted);
            if (produces)
               verdicts_due = {verdicts_due, (row_known ? row_verdict : accepted)};
         end
      end
   end

   // receiver: random back-pressure, plus one long hold on request
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [1:0] fn, input logic [3:0] src, dst,
                            input logic eps, input logic [7:0] sym, input logic tl,
                            input logic known = 1'b0, input logic verdict = 1'b0);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {7'd0, sym, eps, dst, src};
      req_tlast <= tl;
      row_known <= known;
      row_verdict <= verdict;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (fn != FUNC_NOP)
         words_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_edge(input logic eps, input logic [7:0] sym);
      send_item(FUNC_ADD, 4'($urandom_range(15)), 4'($urandom_range(15)), eps, sym,
                1'($urandom_range(1)));
   endtask

   initial begin : stimulus
      int ph;
      int k;
      int len;
      int stop_at;
      logic [7:0] phase_syms [0:3];
      logic [7:0] sym;
      logic [15:0] mask;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < NUM_PROBES; k++) begin
         case (PROBES[k].kind)
            ROW_INIT: begin
               drain_results();
               write_csr(CSR_INITIAL_STATE, PROBES[k].value);
            end
            ROW_MASK: begin
               drain_results();
               write_csr(CSR_FINAL_MASK, PROBES[k].value);
            end
            default: begin
               send_item(PROBES[k].fn, PROBES[k].src, PROBES[k].dst, PROBES[k].eps,
                         PROBES[k].sym, PROBES[k].tl, PROBES[k].known, PROBES[k].verdict);
            end
         endcase
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         if (ph % 6 == 0)
            mask = 16'h0000;
         else if (ph % 6 == 1)
            mask = 16'hFFFF;
         else
            mask = 16'($urandom & $urandom);
         write_csr(CSR_INITIAL_STATE, {12'($urandom_range(4095)),
                   (ph == 1) ? 4'd0 : (ph == 2) ? 4'd15 : 4'($urandom_range(15))});
         write_csr(CSR_FINAL_MASK, mask);
         tx_idle_pct = (ph == 3) ? 0 : 34;
         rx_idle_pct <= (ph == 3) ? 0 : 34;

         for (k = 0; k < 4; k++)
            phase_syms[k] = 8'($urandom_range(255));
         for (k = 0; k < 16; k++)
            add_edge(1'b0, phase_syms[$urandom_range(3)]);
         for (k = 0; k < 3; k++)
            add_edge(1'b1, 8'($urandom_range(255)));

         if (ph == 5) begin
            // stall the result side while queries keep coming
            rx_hold_req <= 1'b1;
            tx_idle_pct = 0;
            for (k = 0; k < 12; k++)
               send_item(FUNC_QRY, 4'($urandom_range(15)), 4'($urandom_range(15)),
                         1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            tx_idle_pct = 34;
         end

         stop_at = words_sent + PHASE_WORDS;
         while (words_sent < stop_at) begin
            k = $urandom_range(99);
            if (k < 5) begin
               send_item(FUNC_QRY, 4'($urandom_range(15)), 4'($urandom_range(15)),
                         1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            end else if (k < 7) begin
               send_item(FUNC_NOP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                         1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            end else if (k < 10) begin
               add_edge(1'($urandom_range(9) == 0), phase_syms[$urandom_range(3)]);
            end else begin
               len = $urandom_range(1, 5);
               for (int n = 1; n <= len; n++) begin
                  if ($urandom_range(99) < 5)
                     add_edge(1'($urandom_range(3) == 0), phase_syms[$urandom_range(3)]);
                  if ($urandom_range(99) < 3 && n < len) begin
                     send_item(FUNC_QRY, 4'd0, 4'd0, 1'b0, 8'($urandom_range(255)), 1'b0);
                     break;
                  end
                  sym = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : phase_syms[$urandom_range(3)];
                  send_item(FUNC_SYM, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            1'($urandom_range(1)), sym, n == len);
               end
            end
         end
      end

      drain_results();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
